// ===== hw/rtl/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared constants, command codes and types of the closest pair sum block.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int DEPTH       = 1024;
    localparam int VALUE_WIDTH = 30;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = VALUE_WIDTH + 1;
    localparam int DIFF_W      = VALUE_WIDTH + 2;

    typedef logic [1:0]             t_cmd;
    typedef logic [VALUE_WIDTH-1:0] t_value;

    // command codes
    localparam t_cmd CMD_LOAD_A = 2'd0;
    localparam t_cmd CMD_LOAD_B = 2'd1;
    localparam t_cmd CMD_SEARCH = 2'd2;

    // status codes
    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/cps_if.sv =====
// ----------------------------------------------------------------------------
// cps_in_if / cps_out_if
// Valid/ready channels of the closest pair sum block: command beats in,
// result beats out.
// ----------------------------------------------------------------------------
interface cps_in_if;
    import cps_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_value value;

    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
endinterface

interface cps_out_if;
    import cps_pkg::*;

    logic   valid;
    logic   ready;
    t_value a_value;
    t_value b_value;
    logic   status;

    modport source (output valid, a_value, b_value, status, input ready);
    modport sink   (input valid, a_value, b_value, status, output ready);
endinterface

// ===== hw/rtl/closest_pair_sum_two_sorted.sv =====
// ----------------------------------------------------------------------------
// closest_pair_sum_two_sorted
// Loads two sorted arrays and finds the pair whose sum lies closest to a
// target with a two-pointer scan over two on-chip memories.
//
//   channel  dir  beat                          when
//   i_in     in   cmd, value                    load A, load B or search
//   o_res    out  a_value, b_value, status      one per search
//
// A search takes one pointer step per cycle (at most a_count + b_count - 1
// steps), then fetches the chosen pair in S_FETCH through the registered
// memory read ports and hands it on in S_DONE. No beat is taken
// while a search runs. A result waits in the output register; loads are taken
// meanwhile, a finished search holds until the register is free.
// Reset clears the state, both counts and the result valid only; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module closest_pair_sum_two_sorted (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cps_in_if.sink     i_in,
    cps_out_if.source  o_res
);
    import cps_pkg::*;

    // array memories
    t_value a_mem [DEPTH];
    t_value b_mem [DEPTH];

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_a_count, n_a_count;
    logic [CNT_W-1:0]   r_b_count, n_b_count;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    t_value             r_target, n_target;
    logic [DIFF_W-1:0]  r_best_diff, n_best_diff;
    logic [ADDR_W-1:0]  r_best_a, n_best_a;
    logic [ADDR_W-1:0]  r_best_b, n_best_b;
    logic               r_empty, n_empty;
    t_value             r_rd_a, r_rd_b;

    logic               r_out_valid, n_out_valid;
    t_value             r_out_a, n_out_a;
    t_value             r_out_b, n_out_b;
    logic               r_out_status, n_out_status;

    logic               we_a, we_b;
    logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
    logic [SUM_W-1:0]   sum;
    logic               over;
    logic [DIFF_W-1:0]  diff;
    logic [CNT_W-1:0]   b_last;

    // pair sum and distance to the target
    assign sum  = {1'b0, r_rd_a} + {1'b0, r_rd_b};
    assign over = sum > {1'b0, r_target};
    assign diff = over ? DIFF_W'(sum - {1'b0, r_target})
                       : DIFF_W'({1'b0, r_target} - sum);
    assign b_last = r_b_count - CNT_W'(1);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_a_count    = r_a_count;
        n_b_count    = r_b_count;
        n_i          = r_i;
        n_j          = r_j;
        n_target     = r_target;
        n_best_diff  = r_best_diff;
        n_best_a     = r_best_a;
        n_best_b     = r_best_b;
        n_empty      = r_empty;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_a      = r_out_a;
        n_out_b      = r_out_b;
        n_out_status = r_out_status;
        we_a         = 1'b0;
        we_b         = 1'b0;
        rd_addr_a    = r_best_a;
        rd_addr_b    = r_best_b;
        i_in.ready   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                rd_addr_a  = '0;
                rd_addr_b  = b_last[ADDR_W-1:0];
                if (i_in.valid) begin
                    case (i_in.cmd)
                        CMD_LOAD_A: begin
                            if (r_a_count != CNT_W'(DEPTH)) begin
                                we_a      = 1'b1;
                                n_a_count = r_a_count + CNT_W'(1);
                            end
                        end
                        CMD_LOAD_B: begin
                            if (r_b_count != CNT_W'(DEPTH)) begin
                                we_b      = 1'b1;
                                n_b_count = r_b_count + CNT_W'(1);
                            end
                        end
                        CMD_SEARCH: begin
                            n_target    = i_in.value;
                            n_i         = '0;
                            n_j         = r_b_count;
                            n_best_diff = '1;
                            n_best_a    = '0;
                            n_best_b    = '0;
                            if (r_a_count == '0 || r_b_count == '0) begin
                                n_empty = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_empty = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // one pointer step per cycle
            S_SCAN: begin
                if (diff == '0) begin
                    n_best_diff = '0;
                    n_best_a    = r_i[ADDR_W-1:0];
                    n_best_b    = ADDR_W'(r_j - CNT_W'(1));
                    n_state     = S_FETCH;
                end else begin
                    if (diff < r_best_diff) begin
                        n_best_diff = diff;
                        n_best_a    = r_i[ADDR_W-1:0];
                        n_best_b    = ADDR_W'(r_j - CNT_W'(1));
                    end else if (diff == r_best_diff && r_i[ADDR_W-1:0] == r_best_a) begin
                        n_best_b    = ADDR_W'(r_j - CNT_W'(1));
                    end
                    if (over) begin
                        n_j = r_j - CNT_W'(1);
                    end else begin
                        n_i = r_i + CNT_W'(1);
                    end
                    if (n_i == r_a_count || n_j == '0) begin
                        n_state = S_FETCH;
                    end else begin
                        rd_addr_a = n_i[ADDR_W-1:0];
                        rd_addr_b = ADDR_W'(n_j - CNT_W'(1));
                    end
                end
            end

            // read the chosen pair
            S_FETCH: begin
                n_state = S_DONE;
            end

            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_a      = r_empty ? '0 : r_rd_a;
                    n_out_b      = r_empty ? '0 : r_rd_b;
                    n_out_status = r_empty ? STATUS_EMPTY : STATUS_FOUND;
                    n_a_count    = '0;
                    n_b_count    = '0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a_count   <= '0;
            r_b_count   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a_count   <= n_a_count;
            r_b_count   <= n_b_count;
            r_out_valid <= n_out_valid;
        end
    end

    // scan and payload registers
    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_j          <= n_j;
        r_target     <= n_target;
        r_best_diff  <= n_best_diff;
        r_best_a     <= n_best_a;
        r_best_b     <= n_best_b;
        r_empty      <= n_empty;
        r_out_a      <= n_out_a;
        r_out_b      <= n_out_b;
        r_out_status <= n_out_status;
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            a_mem[r_a_count[ADDR_W-1:0]] <= i_in.value;
        end
        if (we_b) begin
            b_mem[r_b_count[ADDR_W-1:0]] <= i_in.value;
        end
        r_rd_a <= a_mem[rd_addr_a];
        r_rd_b <= b_mem[rd_addr_b];
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.a_value = r_out_a;
    assign o_res.b_value = r_out_b;
    assign o_res.status  = r_out_status;

endmodule

// ===== tb/tb_closest_pair_sum_two_sorted.sv =====
// ----------------------------------------------------------------------------
// tb_closest_pair_sum_two_sorted
// Self-checking bench for the two-pointer closest pair sum block. Beats load
// arrays A and B and start searches; an in-bench copy of the scan predicts
// each result, and every result beat is compared field by field in order.
// Directed cases cover empty arrays, extreme values, ties, unsorted data and
// the unused command, then a long hold-off at the result side, then random
// load/search runs with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_closest_pair_sum_two_sorted;
    import cps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam t_cmd   CMD_UNUSED = 2'd3;
    localparam t_value VMAX       = {VALUE_WIDTH{1'b1}};
    localparam int     IDLE_LIMIT = 10000;
    localparam int     RAND_BEATS = 235;
    localparam int     RAND_SRCH  = 20;
    localparam int     QUIET_RUN  = 60;

    typedef struct packed {
        t_value a_value;
        t_value b_value;
        logic   status;
    } t_pair_res;

    logic i_clk;
    logic i_rst_n;

    cps_in_if  in_if ();
    cps_out_if res_if ();

    closest_pair_sum_two_sorted u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    // predictor state: loaded arrays and counts
    t_value    a_mem [DEPTH];
    t_value    b_mem [DEPTH];
    int        a_cnt;
    int        b_cnt;
    t_pair_res pending_pairs[$];

    int err_cnt;
    int beats_sent;
    int searches_sent;
    bit quiet;
    int hold_req;

    t_value run_a[$];
    t_value run_b[$];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // two-pointer scan over the loaded arrays, mirrors the block's walk
    function automatic t_pair_res predict_closest_pair(t_value target);
        t_pair_res res;
        int        i;
        int        j;
        int        ai;
        int        bi;
        longint    sum;
        longint    diff;
        longint    best;
        bit        hit;
        res  = '0;
        i    = 0;
        j    = b_cnt;
        ai   = 0;
        bi   = 0;
        best = 64'h7FFF_FFFF_FFFF_FFFF;
        hit  = 1'b0;
        while (i < a_cnt && j > 0 && !hit) begin
            sum  = longint'(a_mem[i]) + longint'(b_mem[j-1]);
            diff = (sum > target) ? sum - target : target - sum;
            if (diff == 0) begin
                ai  = i;
                bi  = j - 1;
                hit = 1'b1;
            end else begin
                if (diff < best) begin
                    best = diff;
                    ai   = i;
                    bi   = j - 1;
                end else if (diff == best && i == ai) begin
                    bi = j - 1;
                end
                if (sum > target) j--;
                else i++;
            end
        end
        res.a_value = a_mem[ai];
        res.b_value = b_mem[bi];
        res.status  = STATUS_FOUND;
        return res;
    endfunction

    // update predictor on an accepted input beat
    function automatic void track_beat(t_cmd cmd, t_value value);
        t_pair_res res;
        case (cmd)
            CMD_LOAD_A: begin
                if (a_cnt < DEPTH) begin
                    a_mem[a_cnt] = value;
                    a_cnt++;
                end
            end
            CMD_LOAD_B: begin
                if (b_cnt < DEPTH) begin
                    b_mem[b_cnt] = value;
                    b_cnt++;
                end
            end
            CMD_SEARCH: begin
                if (a_cnt == 0 || b_cnt == 0) begin
                    res        = '0;
                    res.status = STATUS_EMPTY;
                end else begin
                    res = predict_closest_pair(value);
                end
                pending_pairs.push_back(res);
                a_cnt = 0;
                b_cnt = 0;
            end
            default: ;
        endcase
    endfunction

    // send one beat, with an occasional gap in front of it
    task automatic send_beat(t_cmd cmd, t_value value);
        if (!quiet && $urandom_range(0, 99) < 7) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.value <= value;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        track_beat(cmd, value);
        if (cmd != CMD_UNUSED) beats_sent++;
        if (cmd == CMD_SEARCH) searches_sent++;
    endtask

    // stop offering and wait for all outstanding results
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_pairs.size() != 0);
    endtask

    task automatic send_search(t_value target);
        send_beat(CMD_SEARCH, target);
    endtask

    // ascending distinct values, narrow range makes ties and exact hits likely
    function automatic void build_run(ref t_value q[$], input int n, input bit wide);
        longint lim;
        longint cur;
        longint smax;
        q.delete();
        lim  = wide ? longint'(VMAX) : 63 + n;
        cur  = $urandom_range(0, int'(lim / 2));
        smax = (lim - cur) / n;
        if (smax < 1) smax = 1;
        for (int k = 0; k < n; k++) begin
            q.push_back(t_value'(cur));
            cur += $urandom_range(1, int'(smax));
        end
    endfunction

    // result checker and receiver idling
    initial begin
        int        hold_left;
        t_pair_res exp_res;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (pending_pairs.size() == 0) begin
                    $display("%t: unexpected result a=%0d b=%0d status=%0d", $realtime,
                             res_if.a_value, res_if.b_value, res_if.status);
                    err_cnt++;
                end else begin
                    exp_res = pending_pairs.pop_front();
                    if (res_if.a_value !== exp_res.a_value) begin
                        $display("%t: a_value expected %0d actual %0d", $realtime,
                                 exp_res.a_value, res_if.a_value);
                        err_cnt++;
                    end
                    if (res_if.b_value !== exp_res.b_value) begin
                        $display("%t: b_value expected %0d actual %0d", $realtime,
                                 exp_res.b_value, res_if.b_value);
                        err_cnt++;
                    end
                    if (res_if.status !== exp_res.status) begin
                        $display("%t: status expected %0d actual %0d", $realtime,
                                 exp_res.status, res_if.status);
                        err_cnt++;
                    end
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 7) begin
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any beat on either channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%t: no progress, %0d results outstanding", $realtime,
                         pending_pairs.size());
                $display("tb_closest_pair_sum_two_sorted: done, errors");
                $finish;
            end
        end
    end

    // searches with one or both arrays empty
    task automatic test_empty_arrays();
        send_search(t_value'(0));
        send_beat(CMD_LOAD_A, t_value'(5));
        send_beat(CMD_LOAD_A, t_value'(9));
        send_search(t_value'(14));
        send_beat(CMD_LOAD_B, VMAX);
        send_search(VMAX);
        // counts must be clear after the empty result
        send_search(t_value'(1));
        wait_drain();
    endtask

    // extremes, exact hit, tie on the same A index, unsorted data, unused cmd
    task automatic test_directed_pairs();
        send_beat(CMD_LOAD_A, t_value'(0));
        send_beat(CMD_LOAD_B, t_value'(0));
        send_beat(CMD_LOAD_A, t_value'(10));
        send_beat(CMD_UNUSED, VMAX);
        send_beat(CMD_LOAD_A, VMAX);
        send_beat(CMD_LOAD_B, t_value'(5));
        send_beat(CMD_LOAD_B, VMAX);
        send_search(VMAX);
        // tie: 0+10 and 0+0 both miss 5 by 5
        send_beat(CMD_LOAD_A, t_value'(0));
        send_beat(CMD_LOAD_A, t_value'(10));
        send_beat(CMD_LOAD_B, t_value'(0));
        send_beat(CMD_LOAD_B, t_value'(10));
        send_search(t_value'(5));
        // unsorted and repeated values
        send_beat(CMD_LOAD_A, t_value'(7));
        send_beat(CMD_LOAD_A, t_value'(7));
        send_beat(CMD_LOAD_A, t_value'(2));
        send_beat(CMD_LOAD_B, t_value'(3));
        send_beat(CMD_LOAD_B, t_value'(3));
        send_search(t_value'(9));
        // sum one below the largest against target zero
        send_beat(CMD_LOAD_A, VMAX);
        send_beat(CMD_LOAD_B, VMAX - t_value'(1));
        send_search(t_value'(0));
        wait_drain();
    endtask

    // receiver holds off while searches pile up behind the result register
    task automatic test_backpressure();
        hold_req = 300;
        for (int r = 0; r < 3; r++) begin
            send_beat(CMD_LOAD_A, t_value'($urandom_range(0, 50)));
            send_beat(CMD_LOAD_A, t_value'($urandom_range(51, 100)));
            send_beat(CMD_LOAD_B, t_value'($urandom_range(0, 50)));
            send_beat(CMD_LOAD_B, t_value'($urandom_range(51, 100)));
            send_search(t_value'($urandom_range(0, 200)));
        end
        wait_drain();
    endtask

    // random load/search runs, mostly well formed, some noise;
    // the opening stretch runs with no idling on either side
    task automatic test_random_sequences();
        int     kind;
        int     na;
        int     nb;
        int     ia;
        int     ib;
        int     n;
        bit     wide;
        t_value target;
        beats_sent    = 0;
        searches_sent = 0;
        while (beats_sent < RAND_BEATS || searches_sent < RAND_SRCH) begin
            quiet = (beats_sent < QUIET_RUN);
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                na   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(1, 6);
                nb   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(1, 6);
                wide = 1'($urandom_range(0, 1));
                build_run(run_a, na, wide);
                build_run(run_b, nb, wide);
                ia = 0;
                ib = 0;
                while (ia < na || ib < nb) begin
                    if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
                        send_beat(CMD_LOAD_A, run_a[ia]);
                        ia++;
                    end else begin
                        send_beat(CMD_LOAD_B, run_b[ib]);
                        ib++;
                    end
                end
                case ($urandom_range(0, 3))
                    0: target = run_a[$urandom_range(0, na - 1)]
                              + run_b[$urandom_range(0, nb - 1)];
                    1: target = run_a[$urandom_range(0, na - 1)]
                              + run_b[$urandom_range(0, nb - 1)]
                              + t_value'($urandom_range(0, 6)) - t_value'(3);
                    2: target = t_value'($urandom());
                    default: target = t_value'($urandom_range(0, 255));
                endcase
                send_search(target);
            end else if (kind < 95) begin
                n = $urandom_range(0, 8);
                for (int k = 0; k < n; k++)
                    send_beat(t_cmd'($urandom_range(0, 3)),
                              $urandom_range(0, 1) ? t_value'($urandom())
                                                   : t_value'($urandom_range(0, 63)));
                if ($urandom_range(0, 1)) send_search(t_value'($urandom()));
            end else begin
                send_search(t_value'($urandom()));
            end
            if ($urandom_range(0, 9) == 0) wait_drain();
        end
        quiet = 1'b0;
        wait_drain();
    endtask

    // main sequence
    initial begin
        err_cnt       = 0;
        beats_sent    = 0;
        searches_sent = 0;
        quiet         = 1'b0;
        hold_req      = 0;
        a_cnt         = 0;
        b_cnt         = 0;
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.cmd   <= CMD_LOAD_A;
        in_if.value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_arrays();
        test_directed_pairs();
        test_backpressure();
        test_random_sequences();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (pending_pairs.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("tb_closest_pair_sum_two_sorted: done, clean");
        end else begin
            $display("tb_closest_pair_sum_two_sorted: done, errors");
        end
        $finish;
    end

endmodule
